@@ rtl/core/dsa_pkg.sv @@
// Shared types and constants for the descriptor slot allocator.
package dsa_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int COUNT_BITS = 9;

    localparam logic [2:0] OP_ALLOC_ONE   = 3'd0;
    localparam logic [2:0] OP_ALLOC_THREE = 3'd1;
    localparam logic [2:0] OP_FREE_ONE    = 3'd2;
    localparam logic [2:0] OP_FREE_CHAIN  = 3'd3;
    localparam logic [2:0] OP_SET_LINK    = 3'd4;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NONE_FREE    = 2'd1;
    localparam logic [1:0] ST_RANGE        = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic [2:0]           operation;
        logic [SLOT_BITS-1:0] slot_index;
        logic [SLOT_BITS-1:0] link_target;
        logic                 link_continues;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  first_slot;
        logic [SLOT_BITS-1:0]  second_slot;
        logic [SLOT_BITS-1:0]  third_slot;
        logic [COUNT_BITS-1:0] freed_count;
    } rsp_t;

    typedef struct packed {
        logic       start;
        logic       take;
        logic [1:0] take_pos;
        logic       take_three;
        logic       free_one;
        logic       set_link;
        logic       chain_rd;
        logic       chain_rel;
        logic       load_rsp;
    } dsa_cmd_t;

    typedef struct packed {
        logic any_free;
        logic chain_err;
        logic chain_more;
    } dsa_sts_t;

endpackage

@@ rtl/core/dsa_ctrl.sv @@
// Control state machine of the descriptor slot allocator.
module dsa_ctrl import dsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] op,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output dsa_cmd_t   cmd,
    input  dsa_sts_t   sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC1,
        S_ALLOC3,
        S_FREE,
        S_LINK,
        S_CHAIN_RD,
        S_CHAIN_REL,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] pos_reg, pos_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       rsp_space;
    logic       accept;

    assign rsp_space = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && rsp_space);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if ((state_reg == S_DONE) && rsp_space)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                if (accept)
                begin
                    cmd.start = 1'b1;
                    pos_next  = 2'd0;
                    case (op)
                        OP_ALLOC_ONE:   state_next = S_ALLOC1;
                        OP_ALLOC_THREE: state_next = S_ALLOC3;
                        OP_FREE_ONE:    state_next = S_FREE;
                        OP_FREE_CHAIN:  state_next = S_CHAIN_RD;
                        OP_SET_LINK:    state_next = S_LINK;
                        default:        state_next = S_DONE;
                    endcase
                end
            end
            S_ALLOC1:
            begin
                cmd.take   = 1'b1;
                state_next = S_DONE;
            end
            S_ALLOC3:
            begin
                cmd.take       = 1'b1;
                cmd.take_three = 1'b1;
                cmd.take_pos   = pos_reg;
                if (!sts.any_free || (pos_reg == 2'd2))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 2'd1;
                end
            end
            S_FREE:
            begin
                cmd.free_one = 1'b1;
                state_next   = S_DONE;
            end
            S_LINK:
            begin
                cmd.set_link = 1'b1;
                state_next   = S_DONE;
            end
            S_CHAIN_RD:
            begin
                cmd.chain_rd = 1'b1;
                state_next   = sts.chain_err ? S_DONE : S_CHAIN_REL;
            end
            S_CHAIN_REL:
            begin
                cmd.chain_rel = 1'b1;
                state_next    = sts.chain_more ? S_CHAIN_RD : S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= 2'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

@@ rtl/core/dsa_dpath.sv @@
// Datapath: free map, link store, lowest-free encoder and result registers.
module dsa_dpath import dsa_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  dsa_cmd_t cmd,
    output dsa_sts_t sts,
    output rsp_t     rsp
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam logic [NUM_SLOTS-1:0] LSB_ONE = {{(NUM_SLOTS-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic                 more;
        logic [SLOT_BITS-1:0] next;
    } link_t;

    link_t                link_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] free_reg, free_next;
    logic [NUM_SLOTS-1:0] link_vld_reg, link_vld_next;
    logic [NUM_SLOTS-1:0] taken_reg;
    logic [SLOT_BITS-1:0] cur_reg;
    logic [SLOT_BITS-1:0] tgt_reg;
    logic                 cont_reg;
    link_t                rd_data_reg;
    logic                 rd_vld_reg;
    rsp_t                 work_reg;
    rsp_t                 rsp_reg;

    logic [NUM_SLOTS-1:0] low_onehot;
    logic [IDX_W-1:0]     low_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic                 any_free;
    logic                 in_range;
    logic                 cur_err;
    logic [1:0]           err_code;

    // lowest set bit of the free map, then its index
    assign low_onehot = free_reg & ((~free_reg) + LSB_ONE);
    assign any_free   = |free_reg;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_onehot[i])
            begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign in_range = {1'b0, cur_reg} < COUNT_BITS'(NUM_SLOTS);
    assign cur_err  = !in_range || free_reg[cur_idx];
    assign err_code = in_range ? ST_ALREADY_FREE : ST_RANGE;

    assign sts.any_free   = any_free;
    assign sts.chain_err  = cur_err;
    assign sts.chain_more = rd_vld_reg && rd_data_reg.more;
    assign rsp            = rsp_reg;

    always_comb
    begin
        free_next     = free_reg;
        link_vld_next = link_vld_reg;
        if (cmd.take)
        begin
            if (any_free)
            begin
                free_next = free_reg & ~low_onehot;
            end
            else if (cmd.take_three)
            begin
                // roll back partial triple; taken slots lose their links
                free_next     = free_reg | taken_reg;
                link_vld_next = link_vld_reg & ~taken_reg;
            end
        end
        if ((cmd.free_one || cmd.chain_rd) && !cur_err && cmd.free_one)
        begin
            free_next[cur_idx]     = 1'b1;
            link_vld_next[cur_idx] = 1'b0;
        end
        if (cmd.chain_rel)
        begin
            free_next[cur_idx]     = 1'b1;
            link_vld_next[cur_idx] = 1'b0;
        end
        if (cmd.set_link && in_range)
        begin
            link_vld_next[cur_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg     <= '1;
            link_vld_reg <= '0;
        end
        else
        begin
            free_reg     <= free_next;
            link_vld_reg <= link_vld_next;
        end
    end

    // link store
    always_ff @(posedge clk)
    begin
        if (cmd.set_link && in_range)
        begin
            link_mem[cur_idx] <= link_t'({cont_reg, tgt_reg});
        end
        if (cmd.chain_rd && !cur_err)
        begin
            rd_data_reg <= link_mem[cur_idx];
            rd_vld_reg  <= link_vld_reg[cur_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            work_reg  <= '0;
            taken_reg <= '0;
            cur_reg   <= req.slot_index;
            tgt_reg   <= req.link_target;
            cont_reg  <= req.link_continues;
        end
        if (cmd.take)
        begin
            if (any_free)
            begin
                taken_reg <= taken_reg | low_onehot;
                case (cmd.take_pos)
                    2'd0:    work_reg.first_slot  <= SLOT_BITS'(low_idx);
                    2'd1:    work_reg.second_slot <= SLOT_BITS'(low_idx);
                    default: work_reg.third_slot  <= SLOT_BITS'(low_idx);
                endcase
            end
            else
            begin
                work_reg.status      <= ST_NONE_FREE;
                work_reg.first_slot  <= '0;
                work_reg.second_slot <= '0;
                work_reg.third_slot  <= '0;
            end
        end
        if (cmd.free_one)
        begin
            if (cur_err)
            begin
                work_reg.status <= err_code;
            end
            else
            begin
                work_reg.freed_count <= COUNT_BITS'(1);
            end
        end
        if (cmd.set_link && !in_range)
        begin
            work_reg.status <= ST_RANGE;
        end
        if (cmd.chain_rd && cur_err)
        begin
            work_reg.status <= err_code;
        end
        if (cmd.chain_rel)
        begin
            work_reg.freed_count <= work_reg.freed_count + COUNT_BITS'(1);
            cur_reg              <= rd_data_reg.next;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg <= work_reg;
        end
    end

endmodule

@@ rtl/core/descriptor_slot_allocator.sv @@
// Descriptor slot allocator top level: free map with per-slot links.
// Each request steps through its own control states; unused codes go straight to the done state;
// alloc_three takes slots in turn and ends early when the pool runs out first.
// free_chain: reads then releases each slot freed, and ends on a read when it stops on an error;
// Requests are taken one at a time; a held response lets one more request in, then stalls it.
// Reset: all slots free, all links zero via per-slot valid bits; no clearing pass.
module descriptor_slot_allocator import dsa_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dsa_cmd_t cmd;
    dsa_sts_t sts;

    dsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .op        (req.operation),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dsa_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

@@ rtl/core/dsa_checker.sv @@
// Port-level checks for the descriptor slot allocator, bound to the top level.
module dsa_checker import dsa_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.operation <= OP_SET_LINK) |=> !req_ready)
        else $error("request taken while another is in progress");

    a_triple_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.second_slot != '0) |->
            (rsp.first_slot < rsp.second_slot) && (rsp.second_slot < rsp.third_slot))
        else $error("triple grant not in ascending order");

    a_error_no_triple: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.second_slot == '0) && (rsp.third_slot == '0))
        else $error("failed request reports granted slots");

    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.freed_count <= COUNT_BITS'(NUM_SLOTS))
        else $error("freed count exceeds pool size");

endmodule

bind descriptor_slot_allocator dsa_checker #(.NUM_SLOTS(NUM_SLOTS)) u_dsa_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the descriptor slot allocator with a built-in pool predictor.
`timescale 1ns / 100ps

module testbench;
    import dsa_pkg::*;

    localparam int SLOTS       = 8;
    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 15;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 1000;
    localparam logic [2:0] OP_LAST_CODE = '1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    req_t pending_reqs[$];
    rsp_t pending_outcomes[$];

    logic       pool_free [SLOTS];
    logic [7:0] link_to [SLOTS];
    logic       link_on [SLOTS];

    logic req_taken = 1'b0;
    int   accepted_reqs = 0;
    int   queued_reqs = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    logic calm;

    descriptor_slot_allocator #(.NUM_SLOTS(SLOTS)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    assign calm = (accepted_reqs >= CALM_FROM) && (accepted_reqs < CALM_TO);

    task automatic report_mismatch(string msg);
        $display("cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int lowest_free();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pool_free[i])
                return i;
        end
        return -1;
    endfunction

    function automatic logic [1:0] give_back(int s);
        if (s >= SLOTS)
            return ST_RANGE;
        if (pool_free[s])
            return ST_ALREADY_FREE;
        link_to[s]   = '0;
        link_on[s]   = 1'b0;
        pool_free[s] = 1'b1;
        return ST_OK;
    endfunction

    function automatic rsp_t pool_outcome(req_t r);
        rsp_t       o;
        int         got [3];
        int         n;
        int         s;
        int         cur;
        logic [7:0] nxt;
        logic       more;
        o = '0;
        case (r.operation)
            OP_ALLOC_ONE:
            begin
                s = lowest_free();
                if (s < 0)
                    o.status = ST_NONE_FREE;
                else
                begin
                    pool_free[s] = 1'b0;
                    o.first_slot = 8'(s);
                end
            end
            OP_ALLOC_THREE:
            begin
                n = 0;
                while (n < 3)
                begin
                    s = lowest_free();
                    if (s < 0)
                        break;
                    pool_free[s] = 1'b0;
                    got[n] = s;
                    n++;
                end
                if (n < 3)
                begin
                    // roll back the partial grant
                    for (int j = 0; j < n; j++)
                        void'(give_back(got[j]));
                    o.status = ST_NONE_FREE;
                end
                else
                begin
                    o.first_slot  = 8'(got[0]);
                    o.second_slot = 8'(got[1]);
                    o.third_slot  = 8'(got[2]);
                end
            end
            OP_FREE_ONE:
            begin
                o.status = give_back(int'(r.slot_index));
                if (o.status == ST_OK)
                    o.freed_count = COUNT_BITS'(1);
            end
            OP_FREE_CHAIN:
            begin
                cur = int'(r.slot_index);
                for (int hop = 0; hop <= SLOTS; hop++)
                begin
                    more = 1'b0;
                    nxt  = '0;
                    if (cur < SLOTS)
                    begin
                        more = link_on[cur];
                        nxt  = link_to[cur];
                    end
                    o.status = give_back(cur);
                    if (o.status != ST_OK)
                        break;
                    o.freed_count++;
                    if (!more)
                        break;
                    cur = int'(nxt);
                end
            end
            OP_SET_LINK:
            begin
                if (r.slot_index >= SLOTS)
                    o.status = ST_RANGE;
                else
                begin
                    link_to[r.slot_index] = r.link_target;
                    link_on[r.slot_index] = r.link_continues;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic queue_request(logic [2:0] op, logic [7:0] idx, logic [7:0] tgt, logic cont);
        req_t r;
        r.operation      = op;
        r.slot_index     = idx;
        r.link_target    = tgt;
        r.link_continues = cont;
        pending_reqs.push_back(r);
        queued_reqs++;
    endtask

    function automatic logic [7:0] pick_slot();
        if ($urandom_range(99) < 80)
            return 8'($urandom_range(SLOTS - 1));
        return 8'($urandom_range(255));
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                req_valid <= 1'b1;
                req       <= pending_reqs.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
        rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            req_taken <= req_valid && req_ready;
            if (rsp_valid && rsp_ready)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch($sformatf("response with none expected: %h", rsp));
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.first_slot !== want.first_slot)
                        report_mismatch($sformatf("first_slot got %0d want %0d",
                                                  rsp.first_slot, want.first_slot));
                    if (rsp.second_slot !== want.second_slot)
                        report_mismatch($sformatf("second_slot got %0d want %0d",
                                                  rsp.second_slot, want.second_slot));
                    if (rsp.third_slot !== want.third_slot)
                        report_mismatch($sformatf("third_slot got %0d want %0d",
                                                  rsp.third_slot, want.third_slot));
                    if (rsp.freed_count !== want.freed_count)
                        report_mismatch($sformatf("freed_count got %0d want %0d",
                                                  rsp.freed_count, want.freed_count));
                end
            end
            if (req_valid && req_ready)
            begin
                pending_outcomes.push_back(pool_outcome(req));
                accepted_reqs <= accepted_reqs + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL descriptor_slot_allocator");
            $finish;
        end
    end

    initial
    begin
        int         order [SLOTS];
        int         len;
        int         j;
        int         t;
        int         pick;
        logic [7:0] tgt;
        logic       cont;
        logic [2:0] op;

        for (int i = 0; i < SLOTS; i++)
        begin
            pool_free[i] = 1'b1;
            link_to[i]   = '0;
            link_on[i]   = 1'b0;
        end

        // directed: errors on an empty pool, fill, partial triple, chains
        queue_request(OP_FREE_ONE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_FREE_ONE, 8'd255, 8'd0, 1'b0);
        queue_request(OP_SET_LINK, 8'(SLOTS), 8'd255, 1'b1);
        queue_request(OP_FREE_CHAIN, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_THREE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_THREE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_ONE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_THREE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_ONE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_ONE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_ALLOC_THREE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_SET_LINK, 8'd0, 8'd1, 1'b1);
        queue_request(OP_SET_LINK, 8'd1, 8'd2, 1'b1);
        queue_request(OP_SET_LINK, 8'd2, 8'd200, 1'b1);
        queue_request(OP_FREE_CHAIN, 8'd0, 8'd0, 1'b0);
        queue_request(OP_SET_LINK, 8'd3, 8'd4, 1'b1);
        queue_request(OP_SET_LINK, 8'd4, 8'd3, 1'b1);
        queue_request(OP_FREE_CHAIN, 8'd3, 8'd0, 1'b0);
        queue_request(OP_SET_LINK, 8'd0, 8'd5, 1'b1);
        queue_request(OP_FREE_ONE, 8'd5, 8'd0, 1'b0);
        queue_request(OP_ALLOC_ONE, 8'd0, 8'd0, 1'b0);
        queue_request(OP_FREE_CHAIN, 8'd0, 8'd0, 1'b0);
        queue_request(OP_FREE_ONE, 8'd7, 8'd0, 1'b0);
        queue_request(OP_LAST_CODE, 8'd255, 8'd255, 1'b1);
        queue_request(OP_SET_LINK + 3'd1, 8'd0, 8'd0, 1'b0);

        while (queued_reqs < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 45)
            begin
                // allocate one to three triples and maybe a single slot, link a random chain, then walk it
                len = $urandom_range(SLOTS, 1);
                for (int i = 0; i < SLOTS; i++)
                    order[i] = i;
                for (int i = SLOTS - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                repeat ($urandom_range(3, 1))
                    queue_request(OP_ALLOC_THREE, 8'($urandom), 8'($urandom), 1'($urandom));
                if ($urandom_range(1))
                    queue_request(OP_ALLOC_ONE, 8'($urandom), 8'($urandom), 1'($urandom));
                for (int k = 0; k < len; k++)
                begin
                    if (k < len - 1)
                    begin
                        tgt  = 8'(order[k + 1]);
                        cont = 1'b1;
                    end
                    else
                    begin
                        pick = $urandom_range(99);
                        cont = (pick >= 70);
                        if (pick < 70)
                            tgt = 8'($urandom);
                        else if (pick < 85)
                            tgt = 8'(order[0]);
                        else
                            tgt = 8'($urandom_range(255, SLOTS));
                    end
                    queue_request(OP_SET_LINK, 8'(order[k]), tgt, cont);
                end
                queue_request(OP_FREE_CHAIN, 8'(order[0]), 8'($urandom), 1'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    op = OP_ALLOC_ONE;
                else if (pick < 40)
                    op = OP_ALLOC_THREE;
                else if (pick < 62)
                    op = OP_FREE_ONE;
                else if (pick < 77)
                    op = OP_FREE_CHAIN;
                else if (pick < 95)
                    op = OP_SET_LINK;
                else
                    op = 3'($urandom_range(OP_LAST_CODE, OP_SET_LINK + 3'd1));
                queue_request(op, pick_slot(), pick_slot(), 1'($urandom));
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || pending_outcomes.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("PASS descriptor_slot_allocator");
        else
            $display("FAIL descriptor_slot_allocator");
        $finish;
    end

endmodule
